### src/double_ended_queue_unit_defines.svh
// Assertion macros for the double-ended queue unit.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define DEQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed");
`define DEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");
`else
`define DEQ_ASSERT_SAME(label, ante, cons)
`define DEQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/deq_pkg.sv
// Types and constants shared by the double-ended queue unit.
package deq_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_LIST_FWD   = 3'd4,
    ACT_LIST_REV   = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_t;

  // Result load request from the sequencer to the output register.
  typedef struct packed {
    logic    load;
    logic    use_data;
    status_t status;
    logic    last;
  } deq_res_t;

endpackage

### src/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/deq_ctrl.sv
// Command sequencer: ring indices, entry count, shared index stepper, list walk.
module deq_ctrl import deq_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [ACTION_W-1:0]      in_action,
  input  logic [VALUE_W-1:0]       in_value,
  output logic                     in_ready,
  input  logic                     out_free,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [VALUE_W-1:0]       ram_wdata,
  output logic                     ram_re,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  output deq_res_t                 res
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  state_t             state, state_next;
  action_t            cmd_action;
  logic [VALUE_W-1:0] cmd_value;
  logic [IDX_W-1:0]   front, front_next;
  logic [IDX_W-1:0]   back, back_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   walk, walk_next;
  logic [CNT_W-1:0]   remain, remain_next;
  logic               list_rev, list_rev_next;
  status_t            pend_status, pend_status_next;
  logic               pend_data, pend_data_next;
  logic               pend_list, pend_list_next;

  // Shared index stepper
  logic [IDX_W-1:0] step_src, step_out;
  logic             step_down;

  logic full, empty, final_item;

  assign full       = (count == CNT_FULL);
  assign empty      = (count == '0);
  assign final_item = !pend_list || (remain == CNT_W'(1));
  assign in_ready   = (state == ST_IDLE);
  assign ram_wdata  = cmd_value;

  always_comb begin
    if (step_down) begin
      step_out = (step_src == '0) ? IDX_LAST : step_src - IDX_W'(1);
    end else begin
      step_out = (step_src == IDX_LAST) ? '0 : step_src + IDX_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (cmd_action)
          ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_POP_FRONT,
          ACT_POP_BACK, ACT_LIST_FWD, ACT_LIST_REV: state_next = ST_EMIT;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (out_free && final_item) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Stepper operand, memory port controls and result load
  always_comb begin
    step_src  = front;
    step_down = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = back;
    ram_re    = 1'b0;
    ram_raddr = front;
    res       = '{load: 1'b0, use_data: pend_data, status: pend_status, last: final_item};
    case (state)
      ST_EXEC: begin
        case (cmd_action)
          ACT_PUSH_FRONT: begin
            step_src  = front;
            step_down = 1'b1;
            ram_we    = !full;
            ram_waddr = step_out;
          end
          ACT_PUSH_BACK: begin
            step_src  = back;
            ram_we    = !full;
            ram_waddr = back;
          end
          ACT_POP_FRONT, ACT_LIST_FWD: begin
            step_src  = front;
            ram_re    = !empty;
            ram_raddr = front;
          end
          ACT_POP_BACK, ACT_LIST_REV: begin
            step_src  = back;
            step_down = 1'b1;
            ram_re    = !empty;
            ram_raddr = step_out;
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        res.load  = out_free;
        step_src  = walk;
        step_down = list_rev;
        // fetch the next entry of a listing as this one leaves
        ram_re    = out_free && !final_item;
        ram_raddr = step_out;
      end
      default: ;
    endcase
  end

  always_comb begin
    front_next       = front;
    back_next        = back;
    count_next       = count;
    walk_next        = walk;
    remain_next      = remain;
    list_rev_next    = list_rev;
    pend_status_next = pend_status;
    pend_data_next   = pend_data;
    pend_list_next   = pend_list;
    case (state)
      ST_EXEC: begin
        pend_status_next = STAT_OK;
        pend_data_next   = 1'b0;
        pend_list_next   = 1'b0;
        case (cmd_action)
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (full) begin
              pend_status_next = STAT_FULL;
            end else begin
              count_next = count + CNT_W'(1);
              if (cmd_action == ACT_PUSH_FRONT) front_next = step_out;
              else back_next = step_out;
            end
          end
          ACT_POP_FRONT, ACT_POP_BACK: begin
            if (empty) begin
              pend_status_next = STAT_EMPTY;
            end else begin
              pend_data_next = 1'b1;
              count_next     = count - CNT_W'(1);
              if (cmd_action == ACT_POP_FRONT) front_next = step_out;
              else back_next = step_out;
            end
          end
          ACT_LIST_FWD, ACT_LIST_REV: begin
            if (empty) begin
              pend_status_next = STAT_EMPTY;
            end else begin
              pend_data_next = 1'b1;
              pend_list_next = 1'b1;
              remain_next    = count;
              list_rev_next  = (cmd_action == ACT_LIST_REV);
              walk_next      = (cmd_action == ACT_LIST_REV) ? step_out : front;
            end
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (out_free && !final_item) begin
          walk_next   = step_out;
          remain_next = remain - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      back  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      back  <= back_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_action <= action_t'(in_action);
      cmd_value  <= in_value;
    end
    walk        <= walk_next;
    remain      <= remain_next;
    list_rev    <= list_rev_next;
    pend_status <= pend_status_next;
    pend_data   <= pend_data_next;
    pend_list   <= pend_list_next;
  end

endmodule

### src/double_ended_queue_unit.sv
// Double-ended queue unit of signed 32-bit values held in a RAM ring of DEPTH
// entries. A command is taken when the unit is idle; it then passes through
// the EXEC and EMIT states, and its first result is loaded into the output
// register from EMIT once the output side is free. A push or pop returns to
// idle when its result is loaded. A listing of N entries streams one entry per
// cycle after the first while the output side is free, a rate set by the single
// RAM read port and the one shared index stepper. A finished result may wait in
// the output register while the next command is accepted.
`include "double_ended_queue_unit_defines.svh"

module double_ended_queue_unit import deq_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [VALUE_W-1:0]  s_axis_tdata,  // value[31:0]
  input  logic [ACTION_W-1:0] s_axis_tuser,  // action[2:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [VALUE_W-1:0]  m_axis_tdata,  // item_value[31:0]
  output logic [STATUS_W-1:0] m_axis_tuser,  // status[1:0]
  output logic                m_axis_tlast
);

  localparam int IDX_W = $clog2(DEPTH);

  logic               out_free;
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;
  deq_res_t           res;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_value  (s_axis_tdata),
    .in_ready  (s_axis_tready),
    .out_free  (out_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .res       (res)
  );

  deq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      m_axis_tdata <= res.use_data ? ram_rdata : '0;
      m_axis_tuser <= res.status;
      m_axis_tlast <= res.last;
    end
  end

  `DEQ_ASSERT_SAME(a_err_zero, m_axis_tvalid && (m_axis_tuser != STAT_OK), m_axis_tdata == '0)
  `DEQ_ASSERT_SAME(a_err_last, m_axis_tvalid && (m_axis_tuser != STAT_OK), m_axis_tlast)
  `DEQ_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `DEQ_ASSERT_SAME(a_no_overwrite, res.load, out_free)

endmodule
